/* src/pgic_pkg.sv */
`default_nettype none
package pgic_pkg;

  // default key queue depth
  localparam int KEY_QUEUE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_KEY     = 2'd1,
    REQ_TIMER   = 2'd2,
    REQ_CONTROL = 2'd3
  } pgic_req_t;

  // register addresses
  localparam logic [5:0] ADDR_ROW_LIMIT = 6'd4;
  localparam logic [5:0] ADDR_PORT0     = 6'h3a;
  localparam logic [5:0] ADDR_PORT1     = 6'h3b;
  localparam logic [5:0] ADDR_STATUS    = 6'h3c;
  localparam logic [5:0] ADDR_KEY       = 6'h3e;

  // fixed read values
  localparam logic [7:0] PORT0_DATA = 8'hfe;
  localparam logic [7:0] PORT1_DATA = 8'hff;

  // interrupt status codes
  localparam logic [7:0] ST_KEY     = 8'h00;
  localparam logic [7:0] ST_CONTROL = 8'h08;
  localparam logic [7:0] ST_TIMER   = 8'h09;

  // press flag in queued key codes
  localparam logic [7:0] KEY_PRESS_FLAG = 8'h80;

  // key queue control
  typedef struct packed {
    logic push;
    logic pop;
  } pgic_qctl_t;

endpackage
`default_nettype wire

/* src/pgic_key_fifo.sv */
`default_nettype none
module pgic_key_fifo #(
  parameter int DEPTH = pgic_pkg::KEY_QUEUE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pgic_pkg::pgic_qctl_t ctl,
  input  wire logic [7:0]         wr_data,
  output logic      [7:0]         head,
  output logic      [CW-1:0]      count
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    head_r;
  logic          wr_en;
  logic          do_pop;

  // push and pop on an empty queue pass straight through
  assign wr_en  = ctl.push && !((count_r == '0) && ctl.pop);
  assign do_pop = ctl.pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(wr_en) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage plus registered head read with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (wr_en && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wr_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign head  = head_r;
  assign count = count_r;

endmodule
`default_nettype wire

/* src/panel_gate_array_irq_controller_core.sv */
// the input register, then the result register, lie between an input transfer and its result
// throughput: one item per cycle unless out_ready stalls; one pass of logic per item
// the key queue head is prefetched from its memory into a register, so no stall
// reset: synchronous active-low rst_n clears held keys, interrupt state and queue pointers
// key queue storage is not cleared; it is only read after being written
`default_nettype none
module panel_gate_array_irq_controller_core #(
  parameter int KEY_QUEUE_DEPTH = pgic_pkg::KEY_QUEUE_DEPTH_DEF,
  localparam int CW = $clog2(KEY_QUEUE_DEPTH + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [5:0] in_reg_addr,
  input  wire logic [4:0] in_key_code,
  input  wire logic       in_key_pressed,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_read_data,
  output logic            out_irq_line,
  output logic            out_key_dropped
);

  // ---------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------
  logic       s1_valid_r;
  logic [1:0] s1_type_r;
  logic [5:0] s1_addr_r;
  logic [4:0] s1_code_r;
  logic       s1_pressed_r;

  // result register stage
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_irq_r;
  logic       out_dropped_r;

  // s1 item moves into the result register when that register is free
  logic advance;
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type_r    <= in_req_type;
      s1_addr_r    <= in_reg_addr;
      s1_code_r    <= in_key_code;
      s1_pressed_r <= in_key_pressed;
    end
  end

  // ---------------------------------------------------------------
  // architectural state
  // ---------------------------------------------------------------
  logic [31:0] held_r, held_nxt;
  logic [7:0]  status_r, status_nxt;     // interrupt status code
  logic [7:0]  key_r, key_nxt;           // delivered key code
  logic        pending_r, pending_nxt;   // interrupt line level
  logic        timer_r, timer_nxt;
  logic        ctrl_r, ctrl_nxt;

  // key queue
  pgic_pkg::pgic_qctl_t q_ctl;
  logic [7:0]           q_wr_data;
  logic [7:0]           q_head;
  logic [CW-1:0]        q_count;

  pgic_key_fifo #(
    .DEPTH (KEY_QUEUE_DEPTH)
  ) u_key_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_data (q_wr_data),
    .head    (q_head),
    .count   (q_count)
  );

  // ---------------------------------------------------------------
  // single-pass item logic
  // ---------------------------------------------------------------
  logic [7:0] rd_data;
  logic       dropped;
  logic       push;
  logic       pop;
  logic       try_deliver;
  logic       has_key;

  // queued code: bit 7 marks a press
  assign q_wr_data = s1_pressed_r ? (pgic_pkg::KEY_PRESS_FLAG | {3'b000, s1_code_r})
                                  : {3'b000, s1_code_r};

  always_comb begin
    held_nxt    = held_r;
    status_nxt  = status_r;
    key_nxt     = key_r;
    pending_nxt = pending_r;
    timer_nxt   = timer_r;
    ctrl_nxt    = ctrl_r;
    rd_data     = '0;
    dropped     = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    try_deliver = 1'b0;

    unique case (pgic_pkg::pgic_req_t'(s1_type_r))
      pgic_pkg::REQ_READ: begin
        if (s1_addr_r < pgic_pkg::ADDR_ROW_LIMIT) begin
          // scan row byte of the held bitmap
          rd_data = held_r[s1_addr_r[1:0]*8 +: 8];
        end else begin
          unique case (s1_addr_r)
            pgic_pkg::ADDR_PORT0: rd_data = pgic_pkg::PORT0_DATA;
            pgic_pkg::ADDR_PORT1: rd_data = pgic_pkg::PORT1_DATA;
            pgic_pkg::ADDR_STATUS: begin
              rd_data = status_r;
              // status read acknowledges a tick
              if (pending_r && (status_r != pgic_pkg::ST_KEY)) begin
                pending_nxt = 1'b0;
                try_deliver = 1'b1;
              end
            end
            pgic_pkg::ADDR_KEY: begin
              rd_data = key_r;
              // key-code read acknowledges a key
              if (pending_r && (status_r == pgic_pkg::ST_KEY)) begin
                pending_nxt = 1'b0;
                try_deliver = 1'b1;
              end
            end
            default: rd_data = '0;
          endcase
        end
      end
      pgic_pkg::REQ_KEY: begin
        held_nxt[s1_code_r] = s1_pressed_r;
        if (q_count < CW'(KEY_QUEUE_DEPTH)) begin
          push = 1'b1;
        end else begin
          dropped = 1'b1;
        end
        try_deliver = !pending_r;
      end
      pgic_pkg::REQ_TIMER: begin
        timer_nxt   = 1'b1;
        try_deliver = !pending_r;
      end
      pgic_pkg::REQ_CONTROL: begin
        ctrl_nxt    = 1'b1;
        try_deliver = !pending_r;
      end
      default: ;
    endcase

    // delivery by priority: key, control tick, timer tick
    has_key = (q_count != '0) || push;
    if (try_deliver) begin
      if (has_key) begin
        pop         = 1'b1;
        status_nxt  = pgic_pkg::ST_KEY;
        // empty queue: the code just pushed goes straight out
        key_nxt     = (q_count == '0) ? q_wr_data : q_head;
        pending_nxt = 1'b1;
      end else if (ctrl_nxt) begin
        ctrl_nxt    = 1'b0;
        status_nxt  = pgic_pkg::ST_CONTROL;
        pending_nxt = 1'b1;
      end else if (timer_nxt) begin
        timer_nxt   = 1'b0;
        status_nxt  = pgic_pkg::ST_TIMER;
        pending_nxt = 1'b1;
      end
    end
  end

  // queue only moves when the item actually completes
  assign q_ctl.push = advance && push;
  assign q_ctl.pop  = advance && pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      status_r  <= '0;
      key_r     <= '0;
      pending_r <= 1'b0;
      timer_r   <= 1'b0;
      ctrl_r    <= 1'b0;
    end else if (advance) begin
      held_r    <= held_nxt;
      status_r  <= status_nxt;
      key_r     <= key_nxt;
      pending_r <= pending_nxt;
      timer_r   <= timer_nxt;
      ctrl_r    <= ctrl_nxt;
    end
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r    <= rd_data;
      out_irq_r     <= pending_nxt;
      out_dropped_r <= dropped;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_irq_line    = out_irq_r;
  assign out_key_dropped = out_dropped_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // queued keys always have one delivered ahead of them
  a_queue_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count != '0) |-> pending_r)
    else $error("key queue not empty while interrupt line idle");

  // ticks only wait while the line is busy
  a_ticks_wait_on_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> (!timer_r && !ctrl_r))
    else $error("tick left pending while interrupt line idle");

  // queue never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(KEY_QUEUE_DEPTH))
    else $error("key queue count over depth");

  // a dropped key only happens with a full queue
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && dropped) |-> (q_count == CW'(KEY_QUEUE_DEPTH)))
    else $error("key dropped while queue had room");

endmodule
`default_nettype wire
